// ===== src/ppcrp_pkg.sv =====
// Shared types, relocation type codes and decode types for the PowerPC relocation patcher.
package ppcrp_pkg;

	// relocation type codes, PowerPC ELF ABI numbering
	localparam logic [7:0] RT_ADDR32          = 8'd1;
	localparam logic [7:0] RT_ADDR24          = 8'd2;
	localparam logic [7:0] RT_ADDR16          = 8'd3;
	localparam logic [7:0] RT_ADDR16_LO       = 8'd4;
	localparam logic [7:0] RT_ADDR16_HI       = 8'd5;
	localparam logic [7:0] RT_ADDR16_HA       = 8'd6;
	localparam logic [7:0] RT_ADDR14          = 8'd7;
	localparam logic [7:0] RT_ADDR14_BRTAKEN  = 8'd8;
	localparam logic [7:0] RT_ADDR14_BRNTAKEN = 8'd9;
	localparam logic [7:0] RT_REL24           = 8'd10;
	localparam logic [7:0] RT_REL14           = 8'd11;
	localparam logic [7:0] RT_REL14_BRTAKEN   = 8'd12;
	localparam logic [7:0] RT_REL14_BRNTAKEN  = 8'd13;
	localparam logic [7:0] RT_UADDR32         = 8'd24;
	localparam logic [7:0] RT_UADDR16         = 8'd25;
	localparam logic [7:0] RT_REL32           = 8'd26;
	localparam logic [7:0] RT_SECTOFF         = 8'd33;
	localparam logic [7:0] RT_SECTOFF_LO      = 8'd34;
	localparam logic [7:0] RT_SECTOFF_HI      = 8'd35;
	localparam logic [7:0] RT_SECTOFF_HA      = 8'd36;
	localparam logic [7:0] RT_ADDR30          = 8'd37;
	localparam logic [7:0] RT_NADDR32         = 8'd101;
	localparam logic [7:0] RT_NADDR16         = 8'd102;
	localparam logic [7:0] RT_NADDR16_LO      = 8'd103;
	localparam logic [7:0] RT_NADDR16_HI      = 8'd104;
	localparam logic [7:0] RT_NADDR16_HA      = 8'd105;

	// field masks of the merged instruction forms
	localparam logic [31:0] KEEP_B24   = 32'hfc000003;
	localparam logic [31:0] FIELD_B24  = 32'h03fffffc;
	localparam logic [31:0] KEEP_B14   = 32'hffff0003;
	localparam logic [31:0] FIELD_B14  = 32'h0000fffc;
	localparam logic [31:0] KEEP_B14H  = 32'hffdf0003;
	localparam logic [31:0] HINT_TAKEN = 32'h00200000;
	localparam logic [31:0] KEEP_A30   = 32'h00000003;
	localparam logic [31:0] FIELD_A30  = 32'hfffffffc;
	localparam logic [15:0] HALF_MASK  = 16'hffff;

	typedef struct packed {
		logic [7:0]         kind;
		logic [31:0]        base_address;
		logic [31:0]        target_offset;
		logic signed [31:0] addend;
		logic [31:0]        symbol_address;
		logic [31:0]        old_word;
	} item_t;

	typedef struct packed {
		logic [31:0] patched_value;
		logic        write_size;
		logic        type_ok;
	} result_t;

	// how the relocation value is formed
	typedef enum logic [1:0] {
		VOP_ABS  = 2'd0,
		VOP_REL  = 2'd1,
		VOP_SECT = 2'd2,
		VOP_NEG  = 2'd3
	} value_op_t;

	// how the value lands in the target
	typedef enum logic [3:0] {
		MOP_WORD  = 4'd0,
		MOP_B24   = 4'd1,
		MOP_B14   = 4'd2,
		MOP_B14_T = 4'd3,
		MOP_B14_N = 4'd4,
		MOP_A30   = 4'd5,
		MOP_LO    = 4'd6,
		MOP_HI    = 4'd7,
		MOP_HA    = 4'd8
	} merge_op_t;

	typedef struct packed {
		logic      ok;
		value_op_t vop;
		merge_op_t mop;
	} decode_t;

endpackage

// ===== src/ppcrp_decode.sv =====
// Relocation type decoder: maps the type code to value and merge operations.
module ppcrp_decode (
	input  logic [7:0]       kind,
	output ppcrp_pkg::decode_t dec
);
	import ppcrp_pkg::*;

	// pick the value formula and the known-type flag
	always_comb begin
		dec.ok  = 1'b1;
		dec.vop = VOP_ABS;
		dec.mop = MOP_WORD;
		case (kind)
			RT_ADDR32, RT_ADDR24, RT_ADDR16, RT_ADDR16_HI, RT_ADDR16_HA, RT_ADDR16_LO,
			RT_ADDR14, RT_ADDR14_BRTAKEN, RT_ADDR14_BRNTAKEN, RT_UADDR32,
			RT_UADDR16: begin
				dec.vop = VOP_ABS;
			end
			RT_REL24, RT_REL14, RT_REL14_BRTAKEN, RT_REL14_BRNTAKEN, RT_REL32,
			RT_ADDR30: begin
				dec.vop = VOP_REL;
			end
			RT_SECTOFF, RT_SECTOFF_LO, RT_SECTOFF_HI, RT_SECTOFF_HA: begin
				dec.vop = VOP_SECT;
			end
			RT_NADDR32, RT_NADDR16, RT_NADDR16_LO, RT_NADDR16_HI, RT_NADDR16_HA: begin
				dec.vop = VOP_NEG;
			end
			default: begin
				dec.ok = 1'b0;
			end
		endcase

		// pick the merge form
		case (kind)
			RT_ADDR24, RT_REL24:                        dec.mop = MOP_B24;
			RT_ADDR14, RT_REL14:                        dec.mop = MOP_B14;
			RT_ADDR14_BRTAKEN, RT_REL14_BRTAKEN:        dec.mop = MOP_B14_T;
			RT_ADDR14_BRNTAKEN, RT_REL14_BRNTAKEN:      dec.mop = MOP_B14_N;
			RT_ADDR30:                                  dec.mop = MOP_A30;
			RT_ADDR16, RT_UADDR16, RT_NADDR16, RT_ADDR16_LO, RT_SECTOFF_LO,
			RT_NADDR16_LO:                              dec.mop = MOP_LO;
			RT_ADDR16_HI, RT_SECTOFF_HI, RT_NADDR16_HI: dec.mop = MOP_HI;
			RT_ADDR16_HA, RT_SECTOFF_HA, RT_NADDR16_HA: dec.mop = MOP_HA;
			default:                                    dec.mop = MOP_WORD;
		endcase
	end

endmodule

// ===== src/ppcrp_compute.sv =====
// Relocation datapath: forms the value and merges it into the target word or half.
module ppcrp_compute (
	input  ppcrp_pkg::item_t   item,
	input  ppcrp_pkg::decode_t dec,
	output ppcrp_pkg::result_t res
);
	import ppcrp_pkg::*;

	logic [31:0] addend_u;
	logic [31:0] value;
	logic [15:0] half_ha;

	assign addend_u = item.addend;

	// form the relocation value, all sums wrap modulo 2^32
	always_comb begin
		case (dec.vop)
			VOP_ABS:  value = item.symbol_address + addend_u;
			VOP_REL:  value = item.symbol_address + addend_u - item.base_address
			                  - item.target_offset;
			VOP_SECT: value = item.target_offset + addend_u;
			VOP_NEG:  value = addend_u - item.symbol_address;
			default:  value = '0;
		endcase
	end

	// high-adjusted half: round up when bit 15 is set
	assign half_ha = value[31:16] + {15'd0, value[15]};

	// merge into the old word or select the half
	always_comb begin
		res.patched_value = '0;
		res.write_size    = 1'b0;
		res.type_ok       = dec.ok;
		if (dec.ok) begin
			case (dec.mop)
				MOP_WORD:  res.patched_value = value;
				MOP_B24:   res.patched_value = (item.old_word & KEEP_B24) | (value & FIELD_B24);
				MOP_B14:   res.patched_value = (item.old_word & KEEP_B14) | (value & FIELD_B14);
				MOP_B14_T: res.patched_value = (item.old_word & KEEP_B14H)
				                               | (value & FIELD_B14) | HINT_TAKEN;
				MOP_B14_N: res.patched_value = (item.old_word & KEEP_B14H) | (value & FIELD_B14);
				MOP_A30:   res.patched_value = (item.old_word & KEEP_A30) | (value & FIELD_A30);
				MOP_LO: begin
					res.patched_value = {16'd0, value[15:0] & HALF_MASK};
					res.write_size    = 1'b1;
				end
				MOP_HI: begin
					res.patched_value = {16'd0, value[31:16]};
					res.write_size    = 1'b1;
				end
				MOP_HA: begin
					res.patched_value = {16'd0, half_ha};
					res.write_size    = 1'b1;
				end
				default: res.patched_value = '0;
			endcase
		end
	end

endmodule

// ===== src/ppc_relocation_patcher_unit.sv =====
// Top level of the PowerPC relocation patcher: input register, datapath, result register.
//
//  channel  | ports              | handshake
//  ---------+--------------------+-------------------------------------------
//  command  | start, busy, item  | transaction taken when start && !busy
//  result   | done, result       | one-cycle strobe, receiver cannot stall
//
// done rises once the relocation has passed both registers: the input register
// holds the relocation while the decode and merge logic feeds the result register,
// and the result register takes the result while done_s2 raises done.
// A new relocation is taken every cycle; busy stays low, as nothing stalls.
// Reset clears the valid flags only; payload registers are not reset.
module ppc_relocation_patcher_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ppcrp_pkg::item_t    item,
	output logic                done,
	output ppcrp_pkg::result_t  result
);
	import ppcrp_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	decode_t dec;
	result_t res_comb;
	logic    done_s2;
	result_t result_s2;

	assign busy = 1'b0;

	// capture the command transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	ppcrp_decode u_decode (
		.kind (item_s1.kind),
		.dec  (dec)
	);

	ppcrp_compute u_compute (
		.item (item_s1),
		.dec  (dec),
		.res  (res_comb)
	);

	// register the result and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= res_comb;
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

	// checks
	a_done_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(valid_s1))
		else $error("result strobe does not follow the input stage");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.type_ok |-> result.patched_value == 32'd0 && !result.write_size)
		else $error("unknown type produced a write");

	a_half_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.write_size |-> result.patched_value[31:16] == 16'd0)
		else $error("halfword result has nonzero upper bits");

	a_one_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted relocation produced no result");

endmodule
